// ===== sv/ssm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted set merge engine: payload structs, operation and mode codes.
// No dependencies; imported by every module of the block.
package ssm_pkg;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } ssm_op_e;

  typedef enum logic [1:0] {
    MODE_UNION = 2'd0,
    MODE_DIFF  = 2'd1,
    MODE_ISECT = 2'd2,
    MODE_MERGE = 2'd3
  } ssm_mode_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } ssm_in_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
    logic               empty_result;
    logic               overflow;
    logic [5:0]         result_count;
  } ssm_out_t;

endpackage

// ===== sv/ssm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, drops unknown operation codes and queues commands.
// Depends on ssm_pkg for the input struct and operation codes.
module ssm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  ssm_pkg::ssm_in_t in_item_i,
  output logic            full,
  output logic            cmd_valid_o,
  output ssm_pkg::ssm_in_t cmd_o,
  input  logic            cmd_take_i
);
  import ssm_pkg::*;

  localparam int PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CntW = $clog2(CMD_DEPTH + 1);

  ssm_in_t         fifo_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            known_op;
  logic            enq;
  logic            deq;

  assign full        = (cnt_q == CntW'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // only loads and starts go on; any other code is accepted and dropped
  assign known_op = (in_item_i.operation == OP_LOAD_A) ||
                    (in_item_i.operation == OP_LOAD_B) ||
                    (in_item_i.operation == OP_START);
  assign enq = push && !full && known_op;
  assign deq = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    case ({enq, deq})
      2'b10:   cnt_d = CntW'(cnt_q + 1'b1);
      2'b01:   cnt_d = CntW'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== sv/ssm_back.sv =====
`timescale 1ns / 1ps
// Back end: list stores, two-pointer walk into a result buffer, drain to the output register.
// Depends on ssm_pkg for structs, operation and mode codes.
module ssm_back #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssm_pkg::ssm_mode_e mode_i,
  input  logic               cmd_valid_i,
  input  ssm_pkg::ssm_in_t   cmd_i,
  output logic               cmd_take_o,
  input  logic               pop_i,
  output logic               out_valid_o,
  output ssm_pkg::ssm_out_t  out_item_o
);
  import ssm_pkg::*;

  localparam int IdxW     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CntW     = $clog2(LIST_DEPTH + 1);
  localparam int BufDepth = 2 * LIST_DEPTH;
  localparam int BufIdxW  = $clog2(BufDepth);
  localparam int LenW     = $clog2(BufDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_DRAIN_RD,
    S_DRAIN_WR,
    S_EMPTY
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] ca_q, ca_d, cb_q, cb_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [LenW-1:0] len_q, len_d, k_q, k_d;
  logic            ovf_q, ovf_d;
  logic            snap_q, snap_d;
  logic            out_vld_q, out_vld_d;
  ssm_out_t        out_q, out_d;

  logic [31:0] mem_a_q [LIST_DEPTH];
  logic [31:0] mem_b_q [LIST_DEPTH];
  logic [31:0] buf_q   [BufDepth];
  logic [31:0] rd_a_q, rd_b_q, rd_buf_q;

  logic        ld_a, ld_b;
  logic        has_a, has_b, a_lt, a_eq;
  logic        push_en, adv_a, adv_b, walk_done;
  logic [31:0] push_val;
  logic        out_free, out_load, drain_last;

  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign ld_a = cmd_take_o && (cmd_i.operation == OP_LOAD_A) && (ca_q < CntW'(LIST_DEPTH));
  assign ld_b = cmd_take_o && (cmd_i.operation == OP_LOAD_B) && (cb_q < CntW'(LIST_DEPTH));

  assign has_a = (i_q < ca_q);
  assign has_b = (j_q < cb_q);
  assign a_lt  = $signed(rd_a_q) < $signed(rd_b_q);
  assign a_eq  = (rd_a_q == rd_b_q);

  assign out_free   = !out_vld_q || pop_i;
  assign drain_last = (LenW'(k_q + 1'b1) == len_q);

  // one step of the two-pointer walk
  always_comb begin
    push_en   = 1'b0;
    push_val  = rd_a_q;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    walk_done = 1'b0;
    if (state_q == S_WALK_CMP) begin
      if (has_a && has_b) begin
        unique case (mode_i)
          MODE_UNION: begin
            push_en = 1'b1;
            if (a_lt) begin
              adv_a = 1'b1;
            end else if (!a_eq) begin
              push_val = rd_b_q;
              adv_b    = 1'b1;
            end else begin
              adv_a = 1'b1;
              adv_b = 1'b1;
            end
          end
          MODE_DIFF: begin
            push_en = a_lt;
            adv_a   = a_lt || a_eq;
            adv_b   = !a_lt;
          end
          MODE_ISECT: begin
            push_en = a_eq;
            adv_a   = a_lt || a_eq;
            adv_b   = !a_lt;
          end
          MODE_MERGE: begin
            push_en = 1'b1;
            if (a_lt || a_eq) begin
              adv_a = 1'b1;
            end else begin
              push_val = rd_b_q;
              adv_b    = 1'b1;
            end
          end
          default: walk_done = 1'b1;
        endcase
      end else if (has_a && (mode_i != MODE_ISECT)) begin
        push_en = 1'b1;
        adv_a   = 1'b1;
      end else if (has_b && ((mode_i == MODE_UNION) || (mode_i == MODE_MERGE))) begin
        push_en  = 1'b1;
        push_val = rd_b_q;
        adv_b    = 1'b1;
      end else begin
        walk_done = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    ca_d      = ca_q;
    cb_d      = cb_q;
    i_d       = i_q;
    j_d       = j_q;
    len_d     = len_q;
    k_d       = k_q;
    ovf_d     = ovf_q;
    snap_d    = snap_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    out_load  = 1'b0;

    if (pop_i && out_vld_q) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          case (cmd_i.operation)
            OP_LOAD_A: begin
              if (ld_a) ca_d = CntW'(ca_q + 1'b1);
              else      ovf_d = 1'b1;
            end
            OP_LOAD_B: begin
              if (ld_b) cb_d = CntW'(cb_q + 1'b1);
              else      ovf_d = 1'b1;
            end
            OP_START: begin
              i_d     = '0;
              j_d     = '0;
              len_d   = '0;
              snap_d  = ovf_q;
              state_d = S_WALK_RD;
            end
            default: ;
          endcase
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (adv_a)   i_d   = CntW'(i_q + 1'b1);
        if (adv_b)   j_d   = CntW'(j_q + 1'b1);
        if (push_en) len_d = LenW'(len_q + 1'b1);
        if (walk_done) begin
          // lists are consumed by the start; clear their counts and the overflow flag for the next loads
          ca_d    = '0;
          cb_d    = '0;
          ovf_d   = 1'b0;
          k_d     = '0;
          state_d = (len_q == '0) ? S_EMPTY : S_DRAIN_RD;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_DRAIN_RD: begin
        state_d = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_vld_d          = 1'b1;
          out_d.element      = rd_buf_q;
          out_d.last         = drain_last;
          out_d.empty_result = 1'b0;
          out_d.overflow     = snap_q;
          out_d.result_count = 6'(len_q);
          k_d                = LenW'(k_q + 1'b1);
          state_d            = drain_last ? S_IDLE : S_DRAIN_RD;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_vld_d          = 1'b1;
          out_d.element      = '0;
          out_d.last         = 1'b1;
          out_d.empty_result = 1'b1;
          out_d.overflow     = snap_q;
          out_d.result_count = '0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ca_q      <= '0;
      cb_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      len_q     <= '0;
      k_q       <= '0;
      ovf_q     <= 1'b0;
      snap_q    <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      ca_q      <= ca_d;
      cb_q      <= cb_d;
      i_q       <= i_d;
      j_q       <= j_d;
      len_q     <= len_d;
      k_q       <= k_d;
      ovf_q     <= ovf_d;
      snap_q    <= snap_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  // list stores: one write port for loads, one registered read at the walk pointer
  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      mem_a_q[ca_q[IdxW-1:0]] <= cmd_i.value;
    end
    rd_a_q <= mem_a_q[i_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      mem_b_q[cb_q[IdxW-1:0]] <= cmd_i.value;
    end
    rd_b_q <= mem_b_q[j_q[IdxW-1:0]];
  end

  // result buffer: filled by the walk, read back by the drain
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      buf_q[len_q[BufIdxW-1:0]] <= push_val;
    end
    rd_buf_q <= buf_q[k_q[BufIdxW-1:0]];
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(BufDepth))
    else $error("result length beyond buffer depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_CMP) |-> ((i_q <= ca_q) && (j_q <= cb_q)))
    else $error("walk pointer passed list count");

  a_lists_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |=> ((ca_q == '0) && (cb_q == '0) && !ovf_q))
    else $error("lists not cleared after walk");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (state_q == S_IDLE))
    else $error("back end busy after last beat");

endmodule

// ===== sv/sorted_set_merge_engine.sv =====
`timescale 1ns / 1ps
// Top level of the sorted set merge engine: mode register, front queue and back end.
// Depends on ssm_pkg, ssm_front and ssm_back.
//
//   channel   direction  handshake              payload
//   input     in         push / full            in_item_i  (operation, value)
//   result    out        pop / empty            out_item_o (element, last, empty_result,
//                                                          overflow, result_count)
//   config    in         cfg_we_i               cfg_wdata_i (set_mode)
//
// The idle back end stores a load as it takes it; the two-entry command queue takes pushes.
// A start walks both lists, each step a read then a compare state (registered list reads),
// at most 2*LIST_DEPTH + 1 steps, then drains each result through a read and a write state.
// Reset clears counts, overflow flag and mode; list contents are not cleared.
// The output register holds a result until popped; the back end stalls, the queue fills.
module sorted_set_merge_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              push,
  input  ssm_pkg::ssm_in_t  in_item_i,
  output logic              full,
  output logic              empty,
  output ssm_pkg::ssm_out_t out_item_o,
  input  logic              pop
);
  import ssm_pkg::*;

  ssm_mode_e mode_q;
  logic      cmd_valid;
  ssm_in_t   cmd;
  logic      cmd_take;
  logic      out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UNION;
    end else if (cfg_we_i) begin
      mode_q <= ssm_mode_e'(cfg_wdata_i);
    end
  end

  ssm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  ssm_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule
